// File: sv/assert_macros.svh
// Assertion helpers shared by the RTL files.
// Every macro samples on the rising edge of clk and is held off while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a property holds at every clock edge.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/tspc_pkg.sv
`default_nettype none

package tspc_pkg;

    localparam int POS_W   = 16;
    localparam int PCT_W   = 7;
    localparam int CMD_W   = 4;
    localparam int PLEN_W  = 8;
    localparam int PROD_W  = PCT_W + POS_W;
    localparam int CIDX_W  = 2;
    localparam int CDATA_W = 16;

    // Reciprocal of 25: floor(q * PCT_RECIP >> PCT_SHIFT) == floor(q / 25) for q < 2**21
    localparam int QUO_W     = PROD_W - 2;
    localparam int RECIP_W   = 22;
    localparam logic [RECIP_W-1:0] PCT_RECIP = 22'd2684355;
    localparam int PCT_SHIFT = 26;
    localparam int QLO_W     = 10;
    localparam int QHI_W     = QUO_W - QLO_W;

    localparam logic [POS_W-1:0]  POS_MAX        = '1;
    localparam logic [PLEN_W-1:0] PCNT_MAX       = '1;
    localparam logic [POS_W-1:0]  CYCLE_RESET    = 16'd1;
    localparam logic [PLEN_W-1:0] PLEN_RESET     = 8'd5;

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK   = 4'd0,
        CMD_OPEN   = 4'd1,
        CMD_CLOSE  = 4'd2,
        CMD_TOGGLE = 4'd3,
        CMD_GOTO   = 4'd4,
        CMD_STOP   = 4'd5,
        CMD_HOME   = 4'd6,
        CMD_FORCE  = 4'd7,
        CMD_ACK    = 4'd8,
        CMD_SAVED  = 4'd9
    } cmd_t;

    typedef enum logic [1:0] {
        MODE_PULSE = 2'd0,
        MODE_PERM  = 2'd1,
        MODE_DIR   = 2'd2
    } mode_t;

    typedef enum logic [CIDX_W-1:0] {
        CFG_DRIVE_MODE   = 2'd0,
        CFG_CYCLE_TIME   = 2'd1,
        CFG_PULSE_LENGTH = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic [PCT_W-1:0] percent;
        logic [POS_W-1:0] position_value;
    } in_item_t;

    typedef struct packed {
        logic             do1;
        logic             do2;
        logic [POS_W-1:0] position;
        logic [POS_W-1:0] target;
        logic             moving_up;
        logic             moving_down;
        logic             last_dir_up;
        logic             write_pending;
        logic             position_saved;
        logic             target_reached;
        logic             accepted;
    } out_item_t;

    typedef struct packed {
        logic [1:0]        drive_mode;
        logic [POS_W-1:0]  cycle_time;
        logic [PLEN_W-1:0] pulse_length;
    } cfg_t;

endpackage

`default_nettype wire

// File: sv/tspc_cfg.sv
`default_nettype none

module tspc_cfg (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [tspc_pkg::CIDX_W-1:0]    cfg_index,
    input  wire logic [tspc_pkg::CDATA_W-1:0]   cfg_data,
    output tspc_pkg::cfg_t                      cfg
);

    logic [1:0]                      mode_reg;
    logic [tspc_pkg::POS_W-1:0]      cycle_reg;
    logic [tspc_pkg::PLEN_W-1:0]     plen_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= tspc_pkg::MODE_PULSE;
            cycle_reg <= tspc_pkg::CYCLE_RESET;
            plen_reg  <= tspc_pkg::PLEN_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                tspc_pkg::CFG_DRIVE_MODE:   mode_reg  <= cfg_data[1:0];
                tspc_pkg::CFG_CYCLE_TIME:   cycle_reg <= cfg_data[tspc_pkg::POS_W-1:0];
                tspc_pkg::CFG_PULSE_LENGTH: plen_reg  <= cfg_data[tspc_pkg::PLEN_W-1:0];
                default:                    ;
            endcase
        end
    end

    assign cfg.drive_mode   = mode_reg;
    assign cfg.cycle_time   = cycle_reg;
    assign cfg.pulse_length = plen_reg;

endmodule

`default_nettype wire

// File: sv/tspc_core.sv
`default_nettype none

`include "assert_macros.svh"

module tspc_core (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           step,
    input  wire logic [tspc_pkg::CMD_W-1:0]     cmd,
    input  wire logic [tspc_pkg::PROD_W-1:0]    prod,
    input  wire logic [tspc_pkg::POS_W-1:0]     pos_val,
    input  wire tspc_pkg::cfg_t                 cfg,
    output tspc_pkg::out_item_t                 result
);

    typedef struct packed {
        logic [tspc_pkg::POS_W-1:0]  pos;
        logic [tspc_pkg::POS_W-1:0]  tgt;
        logic [tspc_pkg::PLEN_W-1:0] pcnt;
        logic                        open_act;
        logic                        close_act;
        logic                        open_req;
        logic                        close_req;
        logic                        dir_up;
        logic                        report;
        logic                        saved;
        logic                        out_one;
        logic                        out_two;
    } st_t;

    st_t  st_reg;
    st_t  st_next;
    logic acc;

    logic [tspc_pkg::QUO_W-1:0]                    quo_in;
    logic [tspc_pkg::QHI_W+tspc_pkg::RECIP_W-1:0]  part_hi;
    logic [tspc_pkg::QLO_W+tspc_pkg::RECIP_W-1:0]  part_lo;
    logic [tspc_pkg::QUO_W+tspc_pkg::RECIP_W-1:0]  recip_sum;
    logic [tspc_pkg::POS_W:0]                      sp_raw;
    logic [tspc_pkg::POS_W-1:0]                    sp_pct;

    // Stop any running movement and latch the position as the new setpoint.
    function automatic st_t halt_f(st_t s);
        st_t r;
        r = s;
        if (r.open_act || r.close_act)
        begin
            r.tgt = r.pos;
            if (r.open_act)
            begin
                r.open_act = 1'b0;
                r.open_req = 1'b1;
            end
            if (r.close_act)
            begin
                r.close_act = 1'b0;
                r.close_req = 1'b1;
            end
            r.report = 1'b1;
        end
        return r;
    endfunction

    function automatic st_t seek_f(st_t s, logic [tspc_pkg::POS_W-1:0] sp);
        st_t r;
        r = s;
        r.tgt = sp;
        if (r.pos > sp)
        begin
            if (!r.close_act)
                r.close_req = 1'b1;
            r.open_act  = 1'b0;
            r.close_act = 1'b1;
            r.dir_up    = 1'b0;
            r.report    = 1'b1;
            r.saved     = 1'b0;
        end
        else if (r.pos < sp)
        begin
            if (!r.open_act)
                r.open_req = 1'b1;
            r.open_act  = 1'b1;
            r.close_act = 1'b0;
            r.dir_up    = 1'b1;
            r.report    = 1'b1;
            r.saved     = 1'b0;
        end
        else
        begin
            r.open_act  = 1'b0;
            r.close_act = 1'b0;
        end
        return r;
    endfunction

    function automatic st_t open_f(st_t s, logic [tspc_pkg::POS_W-1:0] cyc);
        st_t r;
        r = s;
        if (r.pos < cyc)
        begin
            if (!r.open_act && !r.close_act)
                r = seek_f(r, cyc);
            else
                r = halt_f(r);
        end
        else
        begin
            r.open_act  = 1'b0;
            r.close_act = 1'b0;
        end
        return r;
    endfunction

    function automatic st_t close_f(st_t s);
        st_t r;
        r = s;
        if (r.pos != '0)
        begin
            if (!r.open_act && !r.close_act)
                r = seek_f(r, '0);
            else
                r = halt_f(r);
        end
        else
        begin
            r.open_act  = 1'b0;
            r.close_act = 1'b0;
        end
        return r;
    endfunction

    // Refresh the motor lines for the selected drive mode.
    function automatic st_t drive_f(st_t s, logic [1:0] mode, logic [tspc_pkg::PLEN_W-1:0] plen);
        st_t r;
        r = s;
        case (mode)
            tspc_pkg::MODE_PULSE:
            begin
                if (r.open_req && (r.pcnt < plen))
                    r.out_one = 1'b1;
                else
                begin
                    r.open_req = 1'b0;
                    r.out_one  = 1'b0;
                end
                if (r.close_req && (r.pcnt < plen))
                    r.out_two = 1'b1;
                else
                begin
                    r.close_req = 1'b0;
                    r.out_two   = 1'b0;
                end
                if (!r.open_req && !r.close_req)
                    r.pcnt = '0;
            end
            tspc_pkg::MODE_PERM:
            begin
                r.out_one = r.open_act;
                if (!r.open_act)
                    r.open_req = 1'b0;
                r.out_two = r.close_act;
                if (!r.close_act)
                    r.close_req = 1'b0;
            end
            tspc_pkg::MODE_DIR:
            begin
                if (r.open_act || r.close_act)
                    r.out_one = 1'b1;
                else
                begin
                    r.out_one = 1'b0;
                    r.out_two = 1'b0;
                end
                if (r.open_act)
                    r.out_two = 1'b0;
                else
                    r.open_req = 1'b0;
                if (r.close_act)
                    r.out_two = 1'b1;
                else
                    r.close_req = 1'b0;
            end
            default: ;
        endcase
        return r;
    endfunction

    // Percent setpoint: prod / 100 as (prod / 4) / 25, reciprocal split in two partial products.
    always_comb
    begin
        quo_in    = prod[tspc_pkg::PROD_W-1:2];
        part_hi   = quo_in[tspc_pkg::QUO_W-1:tspc_pkg::QLO_W] * tspc_pkg::PCT_RECIP;
        part_lo   = quo_in[tspc_pkg::QLO_W-1:0] * tspc_pkg::PCT_RECIP;
        recip_sum = {part_hi, {tspc_pkg::QLO_W{1'b0}}}
                  + {{tspc_pkg::QHI_W{1'b0}}, part_lo};
        sp_raw    = recip_sum[tspc_pkg::PCT_SHIFT +: (tspc_pkg::POS_W + 1)];
        if (sp_raw > {1'b0, cfg.cycle_time})
            sp_pct = cfg.cycle_time;
        else
            sp_pct = sp_raw[tspc_pkg::POS_W-1:0];
    end

    always_comb
    begin
        st_next = st_reg;
        acc     = 1'b0;
        case (cmd)
            tspc_pkg::CMD_TICK:
            begin
                acc = st_reg.open_act || st_reg.close_act;
                if (st_next.close_act && (st_next.pos != '0))
                    st_next.pos = st_next.pos - 1'b1;
                if (st_next.open_act && (st_next.pos != tspc_pkg::POS_MAX))
                    st_next.pos = st_next.pos + 1'b1;
                if ((st_next.open_req || st_next.close_req)
                    && (st_next.pcnt != tspc_pkg::PCNT_MAX))
                    st_next.pcnt = st_next.pcnt + 1'b1;
                if ((st_next.pos >= st_next.tgt) && st_next.open_act)
                    st_next = halt_f(st_next);
                if ((st_next.pos <= st_next.tgt) && st_next.close_act)
                    st_next = halt_f(st_next);
                st_next = drive_f(st_next, cfg.drive_mode, cfg.pulse_length);
            end
            tspc_pkg::CMD_OPEN:
            begin
                acc     = st_reg.pos < cfg.cycle_time;
                st_next = open_f(st_reg, cfg.cycle_time);
            end
            tspc_pkg::CMD_CLOSE:
            begin
                acc     = st_reg.pos != '0;
                st_next = close_f(st_reg);
            end
            tspc_pkg::CMD_TOGGLE:
            begin
                if (st_reg.dir_up)
                begin
                    acc     = st_reg.pos != '0;
                    st_next = close_f(st_reg);
                end
                else
                begin
                    acc     = st_reg.pos < cfg.cycle_time;
                    st_next = open_f(st_reg, cfg.cycle_time);
                end
            end
            tspc_pkg::CMD_GOTO:
            begin
                acc     = st_reg.pos != sp_pct;
                st_next = seek_f(st_reg, sp_pct);
            end
            tspc_pkg::CMD_STOP:
            begin
                acc     = st_reg.open_act || st_reg.close_act;
                st_next = halt_f(st_reg);
            end
            tspc_pkg::CMD_HOME:
            begin
                st_next.pos = cfg.cycle_time;
                acc         = cfg.cycle_time != '0;
                st_next     = close_f(st_next);
            end
            tspc_pkg::CMD_FORCE:
            begin
                if (pos_val > cfg.cycle_time)
                    st_next.pos = cfg.cycle_time;
                else
                    st_next.pos = pos_val;
                st_next.dir_up = st_next.pos != '0;
                acc            = 1'b1;
            end
            tspc_pkg::CMD_ACK:
            begin
                st_next.report = 1'b0;
                acc            = 1'b1;
            end
            tspc_pkg::CMD_SAVED:
            begin
                st_next.saved = 1'b1;
                acc           = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            st_reg <= '0;
        else if (step)
            st_reg <= st_next;
    end

    always_comb
    begin
        result.do1            = st_next.out_one;
        result.do2            = st_next.out_two;
        result.position       = st_next.pos;
        result.target         = st_next.tgt;
        result.moving_up      = st_next.open_act;
        result.moving_down    = st_next.close_act;
        result.last_dir_up    = st_next.dir_up;
        result.write_pending  = st_next.report;
        result.position_saved = st_next.saved;
        result.target_reached = st_next.pos == st_next.tgt;
        result.accepted       = acc;
    end

    `ASSERT_CLK(a_dir_exclusive, !(st_reg.open_act && st_reg.close_act),
        "opening and closing active together")
    `ASSERT_CLK(a_start_reports, !$rose(st_reg.open_act) || st_reg.report,
        "movement started without a pending report")

endmodule

`default_nettype wire

// File: sv/timed_shutter_position_controller.sv
// An accepted item is captured in the input register, then its result is loaded into the result register.
// Throughput: one item per cycle unless out_stall holds the result; the state update for an item is a single
// pass through tspc_core between the input and result registers.
// Reset (rst_n, asynchronous, active low) clears position, setpoint, flags,
// pulse counter and the valid flags of both pipeline registers; config returns to its defaults.
`default_nettype none

`include "assert_macros.svh"

module timed_shutter_position_controller (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    // command items
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire tspc_pkg::in_item_t             in_item,
    // result items
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output tspc_pkg::out_item_t                 out_item,
    // configuration writes
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [tspc_pkg::CIDX_W-1:0]    cfg_index,
    input  wire logic [tspc_pkg::CDATA_W-1:0]   cfg_data
);

    tspc_pkg::cfg_t cfg;

    // Input register: command, percent already scaled by cycle time, forced position.
    logic                            in_vld_reg;
    logic [tspc_pkg::CMD_W-1:0]      cmd_reg;
    logic [tspc_pkg::PROD_W-1:0]     prod_reg;
    logic [tspc_pkg::PROD_W-1:0]     prod_next;
    logic [tspc_pkg::POS_W-1:0]      pval_reg;

    // Result register.
    logic                            out_vld_reg;
    tspc_pkg::out_item_t             res_reg;
    tspc_pkg::out_item_t             res_next;

    logic advance;
    logic step;

    tspc_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Advance whenever the result register is empty or being drained.
    assign advance  = !out_vld_reg || !out_stall;
    assign step     = in_vld_reg && advance;
    assign in_stall = in_vld_reg && !advance;

    // Scale percent by cycle time on the way in; the divide by 100 follows in the core.
    assign prod_next = tspc_pkg::PROD_W'(in_item.percent) * tspc_pkg::PROD_W'(cfg.cycle_time);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_vld_reg <= 1'b0;
        else if (!in_stall)
            in_vld_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            cmd_reg  <= in_item.cmd;
            prod_reg <= prod_next;
            pval_reg <= in_item.position_value;
        end
    end

    tspc_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (step),
        .cmd     (cmd_reg),
        .prod    (prod_reg),
        .pos_val (pval_reg),
        .cfg     (cfg),
        .result  (res_next)
    );

    // Hold the result while stalled; load a new one on each step.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (advance)
            out_vld_reg <= in_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (step)
            res_reg <= res_next;
    end

    assign out_valid = out_vld_reg;
    assign out_item  = res_reg;

    `ASSERT_NEXT(a_step_gives_result, step, out_vld_reg,
        "stepped item produced no result")
    `ASSERT_NEXT(a_blocked_item_kept, in_vld_reg && !advance, in_vld_reg,
        "blocked input item was dropped")

endmodule

`default_nettype wire
